@@ rtl/mbpr_pkg.sv @@
// Shared types, status codes and the CRC-8 step of the packet reassembler.
package mbpr_pkg;

  localparam int FRAME_BYTES = 8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PROGRESS = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR = 3'd2;
  localparam logic [2:0] ST_NO_BUF   = 3'd3;
  localparam logic [2:0] ST_BAD_FMT  = 3'd4;
  localparam logic [2:0] ST_BAD_CRC  = 3'd5;

  localparam logic [1:0] KIND_BAD_ADDR = 2'd0;
  localparam logic [1:0] KIND_START    = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_DATA     = 2'd3;

  typedef struct packed {
    logic [7:0]  function_id;
    logic [7:0]  dest_addr;
    logic [7:0]  source_addr;
    logic [7:0]  marker;
    logic [3:0]  data_count;
    logic [63:0] frame_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] packet_function;
    logic [7:0] packet_source;
    logic [7:0] packet_dest;
    logic [7:0] packet_param;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fn;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [3:0]  cnt;
    logic [63:0] data;
  } cmd_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/mbpr_front.sv @@
// Front end: takes an item, checks the address, decodes the marker and masks the data.
module mbpr_front import mbpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  input  logic [7:0] own_address,
  input  logic [7:0] start_marker,
  input  logic [7:0] end_marker,
  input  logic     q_full,
  output logic     push,
  output cmd_t     push_cmd,
  output logic     pending
);

  logic valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic [3:0] cnt;

  always_comb begin
    cnt = (in_item.data_count > 4'd8) ? 4'd8 : in_item.data_count;
    cmd_nxt.fn  = in_item.function_id;
    cmd_nxt.src = in_item.source_addr;
    cmd_nxt.dst = in_item.dest_addr;
    cmd_nxt.cnt = cnt;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      cmd_nxt.data[i*8 +: 8] = (4'(i) < cnt) ? in_item.frame_data[i*8 +: 8] : 8'd0;
    end
    if (in_item.dest_addr != own_address) begin
      cmd_nxt.kind = KIND_BAD_ADDR;
    end else if (in_item.marker == start_marker) begin
      cmd_nxt.kind = KIND_START;
    end else if (in_item.marker == end_marker) begin
      cmd_nxt.kind = KIND_END;
    end else begin
      cmd_nxt.kind = KIND_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (valid_r && !q_full) begin
      valid_r <= 1'b0;
    end
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign push     = valid_r && !q_full;
  assign push_cmd = cmd_r;
  assign pending  = valid_r;

endmodule

@@ rtl/mbpr_queue.sv @@
// Two-entry command queue between the front end and the back end.
module mbpr_queue import mbpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty,
  output logic full
);

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  assign pop_cmd = ent_r[rp_r];
  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'd2);

endmodule

@@ rtl/mbpr_back.sv @@
// Back end: buffer lookup, packet store, running CRC and result delivery.
module mbpr_back import mbpr_pkg::*; #(
  parameter int NUM_BUFFERS  = 4,
  parameter int PACKET_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       pop,
  input  logic [7:0] crc_poly,
  output logic       out_valid,
  output out_item_t  out_item,
  output logic       busy
);

  localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int LW = $clog2(PACKET_BYTES + 1);
  localparam int DEPTH = NUM_BUFFERS * PACKET_BYTES;
  localparam int AW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]    state_r;
  cmd_t          cmd_r;
  logic [BW-1:0] bsel_r;
  logic [2:0]    wi_r;
  logic [LW-1:0] k_r;
  logic [7:0]    param_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic          act_r [NUM_BUFFERS];
  logic [7:0]    fn_r  [NUM_BUFFERS];
  logic [7:0]    src_r [NUM_BUFFERS];
  logic [7:0]    dst_r [NUM_BUFFERS];
  logic [LW-1:0] len_r [NUM_BUFFERS];
  logic [7:0]    crc_r [NUM_BUFFERS];

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] base;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    wbyte;

  logic          found;
  logic [BW-1:0] fsel;
  logic          match_found;
  logic [LW-1:0] cur_len;
  logic [LW:0]   frames;
  logic [LW:0]   sum_len;

  always_comb begin
    found       = 1'b0;
    match_found = 1'b0;
    fsel        = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (!match_found && act_r[i] && fn_r[i] == cmd_r.fn) begin
        match_found = 1'b1;
        fsel        = BW'(i);
      end
    end
    found = match_found;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (!found && !act_r[i]) begin
        found = 1'b1;
        fsel  = BW'(i);
      end
    end
  end

  assign cur_len = len_r[fsel];
  assign frames  = ({1'b0, cur_len} + (LW+1)'(7)) >> 3;
  assign sum_len = {1'b0, cur_len} + (LW+1)'(cmd_r.cnt);

  assign base   = AW'(PACKET_BYTES) * AW'(bsel_r);
  assign waddr  = base + AW'(len_r[bsel_r]) + AW'(wi_r);
  assign raddr  = base + AW'(k_r);
  assign wbyte  = cmd_r.data[wi_r*8 +: 8];
  assign mem_we = (state_r == S_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wbyte;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        act_r[i] <= 1'b0;
        fn_r[i]  <= 8'd0;
        src_r[i] <= 8'd0;
        dst_r[i] <= 8'd0;
        len_r[i] <= '0;
        crc_r[i] <= 8'd0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_r       <= '0;
          out_r.last  <= 1'b1;
          bsel_r      <= fsel;
          wi_r        <= 3'd0;
          k_r         <= '0;
          param_r     <= cmd_r.data[23:16];
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if (cmd_r.kind == KIND_BAD_ADDR) begin
            out_r.status <= ST_BAD_ADDR;
          end else if (!found) begin
            out_r.status <= ST_NO_BUF;
          end else begin
            case (cmd_r.kind)
              KIND_START: begin
                act_r[fsel]  <= 1'b1;
                len_r[fsel]  <= '0;
                crc_r[fsel]  <= 8'd0;
                fn_r[fsel]   <= cmd_r.fn;
                src_r[fsel]  <= cmd_r.src;
                dst_r[fsel]  <= cmd_r.dst;
                out_r.status <= ST_PROGRESS;
              end
              KIND_END: begin
                act_r[fsel] <= 1'b0;
                if (8'(frames) != cmd_r.data[7:0]) begin
                  out_r.status <= ST_BAD_FMT;
                end else if (crc_r[fsel] != cmd_r.data[15:8]) begin
                  out_r.status <= ST_BAD_CRC;
                end else if (cur_len == '0) begin
                  out_r.status          <= ST_OK;
                  out_r.packet_function <= fn_r[fsel];
                  out_r.packet_source   <= src_r[fsel];
                  out_r.packet_dest     <= dst_r[fsel];
                  out_r.packet_param    <= cmd_r.data[23:16];
                end else begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_RD;
                end
              end
              default: begin
                out_r.status <= ST_PROGRESS;
                if (match_found) begin
                  if (sum_len > (LW+1)'(PACKET_BYTES)) begin
                    act_r[fsel]  <= 1'b0;
                    out_r.status <= ST_BAD_FMT;
                  end else if (cmd_r.cnt != 4'd0) begin
                    out_valid_r <= 1'b0;
                    state_r     <= S_WRITE;
                  end
                end
              end
            endcase
          end
        end
        S_WRITE: begin
          crc_r[bsel_r] <= crc_byte(crc_r[bsel_r], wbyte, crc_poly);
          if ({1'b0, wi_r} == cmd_r.cnt - 4'd1) begin
            len_r[bsel_r] <= len_r[bsel_r] + LW'(cmd_r.cnt);
            out_r         <= '0;
            out_r.status  <= ST_PROGRESS;
            out_r.last    <= 1'b1;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end else begin
            wi_r <= wi_r + 3'd1;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_r.status          <= ST_OK;
          out_r.packet_function <= fn_r[bsel_r];
          out_r.packet_source   <= src_r[bsel_r];
          out_r.packet_dest     <= dst_r[bsel_r];
          out_r.packet_param    <= param_r;
          out_r.data_byte       <= mem_q;
          out_r.byte_valid      <= 1'b1;
          out_r.last            <= ({1'b0, k_r} + (LW+1)'(1)) == {1'b0, len_r[bsel_r]};
          out_valid_r           <= 1'b1;
          if (({1'b0, k_r} + (LW+1)'(1)) == {1'b0, len_r[bsel_r]}) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + LW'(1);
            state_r <= S_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign busy      = (state_r != S_IDLE) || out_valid_r;

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.byte_valid |-> out_r.status == ST_OK)
    else $error("Packet byte delivered with a non-ok status.");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> state_r == S_RD)
    else $error("Result without last while delivery has stopped.");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> {1'b0, wi_r} < cmd_r.cnt)
    else $error("Store write beyond the frame's byte count.");

endmodule

@@ rtl/multi_buffer_packet_reassembler.sv @@
// Top level of the multi-buffer packet reassembler.
// One frame is taken per start pulse while busy is low. Rejected frames, start frames and
// other status-only results pass the front end's register, the queue and the back end's
// command register before the registered result, and busy stays high through that result;
// a data frame also stores its bytes, one byte and one CRC step per cycle. A delivered packet
// alternates a read of the store's registered port with each result; busy stays high.
// Results are strobed on out_valid for one cycle and cannot be stalled by the receiver.
module multi_buffer_packet_reassembler import mbpr_pkg::*; #(
  parameter int NUM_BUFFERS  = 4,
  parameter int PACKET_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [7:0] REG_OWN_ADDR = 8'd0;
  localparam logic [7:0] REG_POLY     = 8'd1;
  localparam logic [7:0] REG_START    = 8'd2;
  localparam logic [7:0] REG_END      = 8'd3;

  logic [7:0] own_address_r;
  logic [7:0] crc_poly_r;
  logic [7:0] start_marker_r;
  logic [7:0] end_marker_r;

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic pending;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t q_cmd;
  logic back_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r  <= 8'd0;
      crc_poly_r     <= 8'd7;
      start_marker_r <= 8'd254;
      end_marker_r   <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ADDR: own_address_r  <= cfg_data;
        REG_POLY:     crc_poly_r     <= cfg_data;
        REG_START:    start_marker_r <= cfg_data;
        REG_END:      end_marker_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy   = pending || !q_empty || back_busy;
  assign accept = start && !busy;

  mbpr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_item      (in_item),
    .own_address  (own_address_r),
    .start_marker (start_marker_r),
    .end_marker   (end_marker_r),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd),
    .pending      (pending)
  );

  mbpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  mbpr_back #(
    .NUM_BUFFERS  (NUM_BUFFERS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .crc_poly  (crc_poly_r),
    .out_valid (out_valid),
    .out_item  (out_item),
    .busy      (back_busy)
  );

endmodule

@@ dv/tb.sv @@
// Testbench for the multi-buffer packet reassembler: random and directed frames.
`timescale 1ns / 1ps
module tb;
  import mbpr_pkg::*;

  localparam int NBUF = 4;
  localparam int PBYTES = 64;
  localparam logic [7:0] REG_ADDR = 8'd0;
  localparam logic [7:0] REG_POLY = 8'd1;
  localparam logic [7:0] REG_START = 8'd2;
  localparam logic [7:0] REG_END = 8'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  multi_buffer_packet_reassembler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [7:0] my_addr, poly, smark, emark;
  logic       b_act [NBUF];
  logic [7:0] b_fn [NBUF], b_src [NBUF], b_dst [NBUF], b_crc [NBUF];
  logic [6:0] b_len [NBUF];
  logic [7:0] store [NBUF*PBYTES];

  in_item_t  frame_q [$];
  out_item_t expected_q [$];
  int  errors = 0;
  int  cycles = 0;
  bit  no_idle = 0;
  bit  cfg_req = 0;
  logic [7:0] cfg_req_idx, cfg_req_val;

  function automatic logic [7:0] crc_step(logic [7:0] c, logic [7:0] d);
    c = c ^ d;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  function automatic void push_status(logic [2:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_frame(in_item_t f);
    logic [7:0] d [8];
    int cnt, b, len, frames;
    bit found;
    out_item_t r;
    cnt = (f.data_count > 4'd8) ? 8 : int'(f.data_count);
    for (int i = 0; i < 8; i++) d[i] = (i < cnt) ? f.frame_data[8*i +: 8] : 8'd0;
    if (f.dest_addr != my_addr) begin
      push_status(ST_BAD_ADDR);
      return;
    end
    found = 0;
    b = 0;
    for (int i = 0; i < NBUF; i++)
      if (!found && b_act[i] && b_fn[i] == f.function_id) begin
        b = i;
        found = 1;
      end
    for (int i = 0; i < NBUF; i++)
      if (!found && !b_act[i]) begin
        b = i;
        found = 1;
      end
    if (!found) begin
      push_status(ST_NO_BUF);
      return;
    end
    if (f.marker == smark) begin
      b_act[b] = 1;
      b_len[b] = 0;
      b_crc[b] = 0;
      b_fn[b] = f.function_id;
      b_src[b] = f.source_addr;
      b_dst[b] = f.dest_addr;
      push_status(ST_PROGRESS);
      return;
    end
    len = (b_len[b] > PBYTES) ? PBYTES : int'(b_len[b]);
    if (f.marker == emark) begin
      frames = (len + 7) >> 3;
      b_act[b] = 0;
      if (frames != d[0]) push_status(ST_BAD_FMT);
      else if (b_crc[b] != d[1]) push_status(ST_BAD_CRC);
      else begin
        r = '0;
        r.status = ST_OK;
        r.packet_function = b_fn[b];
        r.packet_source = b_src[b];
        r.packet_dest = b_dst[b];
        r.packet_param = d[2];
        if (len == 0) begin
          r.last = 1'b1;
          expected_q.push_back(r);
        end else
          for (int k = 0; k < len; k++) begin
            r.data_byte = store[b*PBYTES + k];
            r.byte_valid = 1'b1;
            r.last = (k + 1 == len);
            expected_q.push_back(r);
          end
      end
      return;
    end
    if (b_act[b] && b_fn[b] == f.function_id) begin
      if (len + cnt > PBYTES) begin
        b_act[b] = 0;
        push_status(ST_BAD_FMT);
        return;
      end
      for (int i = 0; i < cnt; i++) begin
        store[b*PBYTES + len + i] = d[i];
        b_crc[b] = crc_step(b_crc[b], d[i]);
      end
      b_len[b] = 7'(len + cnt);
    end
    push_status(ST_PROGRESS);
  endfunction

  // Driver: one frame per accepted start.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) predict_frame(in_item);
      if (start && busy) begin
      end else if (frame_q.size() > 0 && (no_idle || $urandom_range(99) >= 36)) begin
        start <= 1'b1;
        in_item <= frame_q.pop_front();
      end else begin
        start <= 1'b0;
        in_item <= in_item_t'({$urandom, $urandom, $urandom, $urandom});
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ADDR: my_addr = cfg_data;
          REG_POLY: poly = cfg_data;
          REG_START: smark = cfg_data;
          REG_END: emark = cfg_data;
          default: ;
        endcase
        cfg_req = 0;
      end
      if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
      else if (cfg_req) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_req_idx;
        cfg_data <= cfg_req_val;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      out_item_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result %p", out_item);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item.status); errors++;
        end
        if (out_item.packet_function !== e.packet_function) begin
          $error("packet_function exp %0h got %0h", e.packet_function,
                 out_item.packet_function); errors++;
        end
        if (out_item.packet_source !== e.packet_source) begin
          $error("packet_source exp %0h got %0h", e.packet_source, out_item.packet_source);
          errors++;
        end
        if (out_item.packet_dest !== e.packet_dest) begin
          $error("packet_dest exp %0h got %0h", e.packet_dest, out_item.packet_dest);
          errors++;
        end
        if (out_item.packet_param !== e.packet_param) begin
          $error("packet_param exp %0h got %0h", e.packet_param, out_item.packet_param);
          errors++;
        end
        if (out_item.data_byte !== e.data_byte) begin
          $error("data_byte exp %0h got %0h", e.data_byte, out_item.data_byte); errors++;
        end
        if (out_item.byte_valid !== e.byte_valid) begin
          $error("byte_valid exp %0b got %0b", e.byte_valid, out_item.byte_valid); errors++;
        end
        if (out_item.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_item.last); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [7:0] fn, logic [7:0] dst, logic [7:0] mrk,
                                  logic [3:0] cnt, logic [63:0] data);
    in_item_t f;
    f.function_id = fn;
    f.dest_addr = dst;
    f.source_addr = 8'($urandom);
    f.marker = mrk;
    f.data_count = cnt;
    f.frame_data = data;
    return f;
  endfunction

  function automatic logic [7:0] crc_of(logic [7:0] c, logic [63:0] data, int cnt);
    for (int i = 0; i < cnt; i++) c = crc_step(c, data[8*i +: 8]);
    return c;
  endfunction

  // Queues a packet on a function id: well-formed, unless mode corrupts it or its bytes overflow a buffer.
  task automatic queue_packet(logic [7:0] fn, int nframes, int mode);
    logic [7:0] c, seq;
    logic [63:0] d;
    int total, cnt;
    c = 8'd0;
    total = 0;
    frame_q.push_back(mk(fn, my_addr, smark, 4'($urandom_range(15)), {$urandom, $urandom}));
    for (int i = 0; i < nframes; i++) begin
      cnt = ($urandom_range(3) == 0) ? int'($urandom_range(15)) : 8;
      d = {$urandom, $urandom};
      do seq = 8'($urandom); while (seq == smark || seq == emark);
      frame_q.push_back(mk(fn, my_addr, seq, 4'(cnt), d));
      if (cnt > 8) cnt = 8;
      if (total + cnt <= PBYTES) begin
        c = crc_of(c, d, cnt);
        total += cnt;
      end
    end
    d = {$urandom, $urandom};
    d[7:0] = 8'((total + 7) >> 3);
    d[15:8] = c;
    if (mode == 1) d[7:0] ^= 8'h01;
    if (mode == 2) d[15:8] ^= 8'h80;
    frame_q.push_back(mk(fn, my_addr, emark, 4'((mode == 3) ? $urandom_range(2) : 3), d));
  endtask

  task automatic drain();
    wait (frame_q.size() == 0);
    @(posedge clk);
    while (start || busy || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_req_idx = idx;
    cfg_req_val = val;
    cfg_req = 1;
    wait (cfg_req == 0);
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] fn;
    my_addr = 0; poly = 8'h07; smark = 8'd254; emark = 8'd255;
    for (int i = 0; i < NBUF; i++) begin
      b_act[i] = 0; b_fn[i] = 0; b_src[i] = 0; b_dst[i] = 0; b_crc[i] = 0; b_len[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with reset settings.
    frame_q.push_back(mk(8'h10, 8'h00, 8'd255, 4'd3, 64'h0));
    frame_q.push_back(mk(8'h11, 8'hFF, 8'd254, 4'd8, '1));
    frame_q.push_back(mk(8'h12, 8'h00, 8'h05, 4'd8, '1));
    queue_packet(8'h00, 0, 0);
    queue_packet(8'hFF, 2, 0);
    queue_packet(8'h21, 1, 1);
    queue_packet(8'h22, 1, 2);
    for (int i = 0; i < 5; i++) frame_q.push_back(mk(8'(i), 8'h00, 8'd254, 4'd0, 64'h0));
    for (int i = 0; i < 4; i++) frame_q.push_back(mk(8'(i), 8'h00, 8'd255, 4'd8, 64'h0));
    drain();

    write_reg(REG_ADDR, 8'hFF);
    write_reg(REG_POLY, 8'hFF);
    write_reg(REG_START, 8'h00);
    write_reg(REG_END, 8'h00);
    write_reg(8'd9, 8'h55);
    queue_packet(8'h33, 1, 0);
    frame_q.push_back(mk(8'h44, 8'hFF, 8'h00, 4'd0, 64'h0));
    drain();

    write_reg(REG_POLY, 8'h00);
    write_reg(REG_START, 8'hA5);
    write_reg(REG_END, 8'h5A);
    queue_packet(8'h55, 9, 0);
    queue_packet(8'h56, 8, 3);
    drain();

    write_reg(REG_ADDR, 8'h00);
    write_reg(REG_POLY, 8'h07);
    write_reg(REG_START, 8'd254);
    write_reg(REG_END, 8'd255);
    for (int p = 0; p < 40; p++) begin
      if (p == 15) begin
        drain();
        write_reg(REG_ADDR, 8'($urandom));
        write_reg(REG_POLY, 8'($urandom));
      end
      if (p == 25) begin
        drain();
        no_idle = 1;
      end
      if (p == 32) begin
        wait (frame_q.size() == 0);
        no_idle = 0;
      end
      fn = 8'($urandom_range(5));
      case ($urandom_range(9))
        0: frame_q.push_back(in_item_t'({$urandom, $urandom, $urandom, $urandom}));
        1: frame_q.push_back(mk(fn, 8'($urandom), 8'($urandom), 4'($urandom),
                                {$urandom, $urandom}));
        2: queue_packet(fn, int'($urandom_range(3)), int'($urandom_range(1, 3)));
        default: queue_packet(fn, int'($urandom_range(0, 3)), 0);
      endcase
    end
    drain();

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
